/* src/gdo_pkg.sv */
// Package for the Gregorian date offset block: widths, calendar constants,
// the queued job type and the calendar helper functions. No dependencies.
`timescale 1ns / 1ps

package gdo_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int OFFSET_W = 9;
    localparam int DOY_W    = 9;
    // Wide enough for a day of year plus an offset.
    localparam int SUM_W    = 10;

    localparam logic [SUM_W-1:0]   YEAR_LEN      = SUM_W'(365);
    localparam logic [SUM_W-1:0]   LEAP_YEAR_LEN = SUM_W'(366);
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN  = DAY_W'(29);
    localparam logic [DAY_W-1:0]   FEB_LEN       = DAY_W'(28);
    localparam logic [DAY_W-1:0]   SHORT_LEN     = DAY_W'(30);
    localparam logic [DAY_W-1:0]   LONG_LEN      = DAY_W'(31);
    localparam logic [MONTH_W-1:0] JANUARY       = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEBRUARY      = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] DECEMBER      = MONTH_W'(12);

    // Division by 100 through a reciprocal: exact for every 14-bit year.
    localparam int DIV100_RECIP = 10486;
    localparam int DIV100_SHIFT = 20;
    localparam int PROD_W       = 2 * YEAR_W;
    localparam int QUOT_W       = PROD_W - DIV100_SHIFT;

    // Job queue between the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic                action;
        logic [YEAR_W-1:0]   year;
        logic [OFFSET_W-1:0] offset;
        logic                is_leap;
        logic [DOY_W-1:0]    doy;
    } t_job;

    // Leap rule: divisible by 400, or by 4 and not by 100.
    function automatic logic leap_f(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] q;
        logic [YEAR_W-1:0] q100;
        logic              d100;
        prod = {{YEAR_W{1'b0}}, y} * PROD_W'(DIV100_RECIP);
        q    = prod[PROD_W-1:DIV100_SHIFT];
        q100 = YEAR_W'(q) * YEAR_W'(100);
        d100 = (q100 == y);
        return (d100 && (q[1:0] == 2'd0)) || ((y[1:0] == 2'd0) && !d100);
    endfunction

    // Days in the months before month m of a common year.
    function automatic logic [DOY_W-1:0] days_before_f(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] d;
        case (m)
            4'd0:    d = DOY_W'(0);
            4'd1:    d = DOY_W'(0);
            4'd2:    d = DOY_W'(31);
            4'd3:    d = DOY_W'(59);
            4'd4:    d = DOY_W'(90);
            4'd5:    d = DOY_W'(120);
            4'd6:    d = DOY_W'(151);
            4'd7:    d = DOY_W'(181);
            4'd8:    d = DOY_W'(212);
            4'd9:    d = DOY_W'(243);
            4'd10:   d = DOY_W'(273);
            4'd11:   d = DOY_W'(304);
            4'd12:   d = DOY_W'(334);
            default: d = DOY_W'(365);
        endcase
        return d;
    endfunction

    // Length of month m (1 to 11 during the walk).
    function automatic logic [DAY_W-1:0] month_len_f(input logic [MONTH_W-1:0] m,
                                                     input logic lp);
        logic [DAY_W-1:0] len;
        if (m == FEBRUARY) begin
            len = lp ? FEB_LEAP_LEN : FEB_LEN;
        end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = SHORT_LEN;
        end else begin
            len = LONG_LEN;
        end
        return len;
    endfunction

    function automatic logic [SUM_W-1:0] year_len_f(input logic lp);
        return lp ? LEAP_YEAR_LEN : YEAR_LEN;
    endfunction

endpackage

/* src/gdo_if.sv */
// Request and response channel interfaces of the date offset block.
// Depends on gdo_pkg for the field widths.
`timescale 1ns / 1ps

interface gdo_req_if;
    import gdo_pkg::*;
    logic                valid;
    logic                ready;
    logic                action;
    logic [DAY_W-1:0]    in_day;
    logic [MONTH_W-1:0]  in_month;
    logic [YEAR_W-1:0]   in_year;
    logic [OFFSET_W-1:0] offset;

    modport source (output valid, action, in_day, in_month, in_year, offset,
                    input ready);
    modport sink (input valid, action, in_day, in_month, in_year, offset,
                  output ready);
endinterface

interface gdo_rsp_if;
    import gdo_pkg::*;
    logic               valid;
    logic               ready;
    logic               is_leap;
    logic [DOY_W-1:0]   day_of_year;
    logic [DAY_W-1:0]   out_day;
    logic [MONTH_W-1:0] out_month;
    logic [YEAR_W-1:0]  out_year;

    modport source (output valid, is_leap, day_of_year, out_day, out_month, out_year,
                    input ready);
    modport sink (input valid, is_leap, day_of_year, out_day, out_month, out_year,
                  output ready);
endinterface

/* src/gdo_front.sv */
// Front part: registers a request and classifies it (leap flag, day of year).
// Depends on gdo_pkg and gdo_req_if.
`timescale 1ns / 1ps

module gdo_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gdo_req_if.sink       i_req,
    output logic          o_job_valid,
    output gdo_pkg::t_job o_job,
    input  logic          i_job_ready
);
    import gdo_pkg::*;

    logic                r_valid;
    logic                r_action;
    logic [DAY_W-1:0]    r_day;
    logic [MONTH_W-1:0]  r_month;
    logic [YEAR_W-1:0]   r_year;
    logic [OFFSET_W-1:0] r_offset;
    logic                lp;
    logic                feb_bump;

    // A new request may enter when the register is empty or once the held one moves on to the queue.
    assign i_req.ready = !r_valid || i_job_ready;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_action <= i_req.action;
            r_day    <= i_req.in_day;
            r_month  <= i_req.in_month;
            r_year   <= i_req.in_year;
            r_offset <= i_req.offset;
        end
    end

    // Leap flag and ordinal day of the starting date.
    assign lp       = leap_f(r_year);
    assign feb_bump = lp && (r_month > FEBRUARY);

    assign o_job_valid    = r_valid;
    assign o_job.action   = r_action;
    assign o_job.year     = r_year;
    assign o_job.offset   = r_offset;
    assign o_job.is_leap  = lp;
    assign o_job.doy      = days_before_f(r_month) + DOY_W'(r_day) + DOY_W'(feb_bump);

endmodule

/* src/gdo_queue.sv */
// Short job queue that decouples the front and back parts.
// Depends on gdo_pkg.
`timescale 1ns / 1ps

module gdo_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  gdo_pkg::t_job i_push_data,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output gdo_pkg::t_job o_pop_data,
    input  logic          i_pop_ready
);
    import gdo_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

/* src/gdo_back.sv */
// Back part: shifts the date by the offset and walks the months of the
// target year, one month per cycle. Depends on gdo_pkg and gdo_rsp_if.
`timescale 1ns / 1ps

module gdo_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  gdo_pkg::t_job i_job,
    output logic          o_job_ready,
    gdo_rsp_if.source     o_rsp
);
    import gdo_pkg::*;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_YEAR = 2'd1;
    localparam logic [1:0] ST_ADJ  = 2'd2;
    localparam logic [1:0] ST_WALK = 2'd3;

    logic [1:0]         r_state;
    t_job               r_job;
    logic [YEAR_W-1:0]  r_ty;
    logic               r_cross;
    logic [SUM_W-1:0]   r_r;
    logic               r_tlp;
    logic [MONTH_W-1:0] r_m;

    logic               r_ovalid;
    logic               r_oleap;
    logic [DOY_W-1:0]   r_odoy;
    logic [DAY_W-1:0]   r_oday;
    logic [MONTH_W-1:0] r_omonth;
    logic [YEAR_W-1:0]  r_oyear;

    logic [SUM_W-1:0]   sum_add;
    logic [SUM_W-1:0]   ylen;
    logic [SUM_W-1:0]   doy_w;
    logic [SUM_W-1:0]   ofs_w;
    logic               tlp;
    logic [SUM_W-1:0]   back_sum;
    logic [DAY_W-1:0]   mlen;
    logic               step;
    logic               out_free;
    logic               finish;

    assign doy_w    = SUM_W'(r_job.doy);
    assign ofs_w    = SUM_W'(r_job.offset);
    assign sum_add  = doy_w + ofs_w;
    assign ylen     = year_len_f(r_job.is_leap);
    assign tlp      = leap_f(r_ty);
    assign back_sum = doy_w + year_len_f(tlp);
    assign mlen     = month_len_f(r_m, r_tlp);
    assign step     = (r_m < DECEMBER) && (r_r > SUM_W'(mlen));
    assign out_free = !r_ovalid || o_rsp.ready;
    assign finish   = (r_state == ST_WALK) && !step && out_free;

    assign o_job_ready = (r_state == ST_LOAD);

    // Sequencer: load, choose target year, settle residual, month walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (i_job_valid) begin
                        r_state <= ST_YEAR;
                    end
                end
                ST_YEAR: r_state <= ST_ADJ;
                ST_ADJ:  r_state <= ST_WALK;
                ST_WALK: begin
                    if (finish) begin
                        r_state <= ST_LOAD;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    // Datapath registers of the job in progress.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                if (i_job_valid) begin
                    r_job <= i_job;
                end
            end
            ST_YEAR: begin
                r_cross <= 1'b0;
                r_ty    <= r_job.year;
                if (!r_job.action) begin
                    // Add: may run into the next year.
                    if (sum_add <= ylen) begin
                        r_r <= sum_add;
                    end else begin
                        r_ty <= r_job.year + 1'b1;
                        r_r  <= sum_add - ylen;
                    end
                end else begin
                    // Subtract: may fall back into the previous year.
                    if (doy_w > ofs_w) begin
                        r_r <= doy_w - ofs_w;
                    end else begin
                        r_ty    <= r_job.year - 1'b1;
                        r_cross <= 1'b1;
                    end
                end
            end
            ST_ADJ: begin
                r_tlp <= tlp;
                r_m   <= JANUARY;
                // A shortfall of more than a year saturates to January 1.
                if (r_cross) begin
                    r_r <= (back_sum <= ofs_w) ? SUM_W'(1) : back_sum - ofs_w;
                end
            end
            ST_WALK: begin
                if (step) begin
                    r_r <= r_r - SUM_W'(mlen);
                    r_m <= r_m + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (finish) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
        if (finish) begin
            r_oleap  <= r_job.is_leap;
            r_odoy   <= r_job.doy;
            r_oday   <= (r_r > SUM_W'(LONG_LEN)) ? LONG_LEN : r_r[DAY_W-1:0];
            r_omonth <= r_m;
            r_oyear  <= r_ty;
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.is_leap     = r_oleap;
    assign o_rsp.day_of_year = r_odoy;
    assign o_rsp.out_day     = r_oday;
    assign o_rsp.out_month   = r_omonth;
    assign o_rsp.out_year    = r_oyear;

endmodule

/* src/gregorian_date_offset_top.sv */
// Top level of the Gregorian date offset block.
// Depends on gdo_pkg, gdo_if, gdo_front, gdo_queue and gdo_back.
//
// Usage:
//   i_req carries one request per transfer (valid/ready): action (0 add,
//   1 subtract), in_day, in_month, in_year and offset. o_rsp returns one
//   result per request in order: is_leap and day_of_year of the input date,
//   and out_day, out_month, out_year of the shifted date.
//   The front part registers a request and works out the leap flag and day
//   of year; a two-entry queue hands it to the back part, which picks the
//   target year, settles the residual and walks the months one per cycle.
//   The back part takes no new job until it has finished the last one:
//   it passes through its load, year and residual states, then takes one
//   step for each month passed in the walk (up to eleven) plus a final
//   step, so the month walk sets the throughput.
//   When the receiver stalls, the result waits in the output register, the
//   back part holds its finished job, and the queue and the front register
//   keep accepting until they are full. Synchronous active-low reset
//   empties the queue and clears all valid flags; no clearing pass is needed.
`timescale 1ns / 1ps

module gregorian_date_offset_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gdo_req_if.sink   i_req,
    gdo_rsp_if.source o_rsp
);
    import gdo_pkg::*;

    logic front_valid;
    t_job front_job;
    logic front_ready;
    logic back_valid;
    t_job back_job;
    logic back_ready;

    gdo_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_ready (front_ready)
    );

    gdo_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_data  (front_job),
        .o_push_ready (front_ready),
        .o_pop_valid  (back_valid),
        .o_pop_data   (back_job),
        .i_pop_ready  (back_ready)
    );

    gdo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (back_valid),
        .i_job       (back_job),
        .o_job_ready (back_ready),
        .o_rsp       (o_rsp)
    );

endmodule
